// ===== rtl/lkc_pkg.sv =====
// lkc_pkg: shared constants, types and codes for the LRU keyed entry cache.
// Used by lkc_ctrl, lkc_dpath and lru_keyed_entry_cache. No dependencies.
`timescale 1ns / 1ps

package lkc_pkg;

  // Store geometry
  localparam int ENTRIES      = 16;
  localparam int CONN_ID_BITS = 8;
  localparam int KEY_W        = 64;
  localparam int SLOT_W       = $clog2(ENTRIES);
  localparam int RANK_W       = $clog2(ENTRIES);
  localparam int COUNT_W      = $clog2(ENTRIES + 1);
  localparam int CAP_W        = 5;
  localparam int CAP_RESET    = 16;
  localparam int STATUS_W     = 2;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_HIT    = 2'd0,
    STAT_INSERT = 2'd1,
    STAT_EVICT  = 2'd2,
    STAT_FAIL   = 2'd3
  } lkc_status_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_COMMIT
  } lkc_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_in;  // capture an input beat
    logic lookup;   // register tag compare and slot choices
    logic commit;   // update store and load result register
  } lkc_cmd_t;

endpackage

// ===== rtl/lru_keyed_entry_cache.sv =====
// lru_keyed_entry_cache: top level, joins controller and datapath.
// Depends on lkc_pkg, lkc_ctrl and lkc_dpath.
`timescale 1ns / 1ps

// Fully associative cache of 16 keyed entries with least recently used
// replacement. Each input beat looks up a 64-bit key: a hit refreshes the
// entry and returns its slot and connection id; a miss with prepare_ok set
// inserts the key (evicting the oldest entry once occupancy reaches the
// capacity register, clamped to 1..16); a miss without it reports failure.
// Each item is handled in a lookup step, the parallel tag compare and slot
// choice, and then a commit step, the store and recency update, which
// loads the result register. The next beat is taken in the commit cycle,
// while the previous result may still wait at the output.
// The store is empty after reset; no clearing pass is needed. Write the
// capacity register only while the block is idle.
module lru_keyed_entry_cache
  import lkc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration
  input  logic                    cfg_we_i,
  input  logic [CAP_W-1:0]        cfg_wdata_i,
  // input channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [KEY_W-1:0]        key_i,
  input  logic                    prepare_ok_i,
  input  logic [CONN_ID_BITS-1:0] new_conn_id_i,
  // output channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [STATUS_W-1:0]     status_o,
  output logic [SLOT_W-1:0]       slot_o,
  output logic [CONN_ID_BITS-1:0] entry_conn_id_o,
  output logic [KEY_W-1:0]        evicted_key_o,
  output logic [COUNT_W-1:0]      occupancy_o
);

  lkc_cmd_t cmd;

  lkc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  lkc_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .key_i           (key_i),
    .prepare_ok_i    (prepare_ok_i),
    .new_conn_id_i   (new_conn_id_i),
    .status_o        (status_o),
    .slot_o          (slot_o),
    .entry_conn_id_o (entry_conn_id_o),
    .evicted_key_o   (evicted_key_o),
    .occupancy_o     (occupancy_o)
  );

endmodule

// ===== rtl/lkc_ctrl.sv =====
// lkc_ctrl: sequencer for the LRU keyed entry cache (capture, lookup, commit).
// Depends on lkc_pkg; drives lkc_dpath through lkc_cmd_t.
`timescale 1ns / 1ps

module lkc_ctrl
  import lkc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output lkc_cmd_t cmd_o
);

  lkc_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       in_accept;

  // Result register can take a new beat
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !((state_q == ST_IDLE) || ((state_q == ST_COMMIT) && out_free));
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  // State and result-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    cmd_o.load_in  = in_accept;
    cmd_o.lookup   = 1'b0;
    cmd_o.commit   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) state_d = ST_LOOK;
      end
      ST_LOOK: begin
        cmd_o.lookup = 1'b1;
        state_d      = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = in_accept ? ST_LOOK : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = cmd_o.commit || (out_valid_q && out_stall_i);
  end

  // A commit never overwrites a result that is still held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || !out_stall_i))
    else $error("commit over a stalled result");

  // Lookup is always followed by the commit state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOK) |=> (state_q == ST_COMMIT))
    else $error("lookup not followed by commit");

  // An accepted beat starts a lookup next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_LOOK))
    else $error("accepted beat did not start lookup");

endmodule

// ===== rtl/lkc_dpath.sv =====
// lkc_dpath: entry store, recency ranks, tag compare and result register.
// Depends on lkc_pkg; controlled by lkc_ctrl through lkc_cmd_t.
`timescale 1ns / 1ps

module lkc_dpath
  import lkc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lkc_cmd_t                cmd_i,
  input  logic                    cfg_we_i,
  input  logic [CAP_W-1:0]        cfg_wdata_i,
  input  logic [KEY_W-1:0]        key_i,
  input  logic                    prepare_ok_i,
  input  logic [CONN_ID_BITS-1:0] new_conn_id_i,
  output logic [STATUS_W-1:0]     status_o,
  output logic [SLOT_W-1:0]       slot_o,
  output logic [CONN_ID_BITS-1:0] entry_conn_id_o,
  output logic [KEY_W-1:0]        evicted_key_o,
  output logic [COUNT_W-1:0]      occupancy_o
);

  // Entry store
  logic [KEY_W-1:0]        keys_q  [ENTRIES];
  logic [CONN_ID_BITS-1:0] conns_q [ENTRIES];
  logic [RANK_W-1:0]       rank_q  [ENTRIES];
  logic [RANK_W-1:0]       rank_d  [ENTRIES];
  logic [ENTRIES-1:0]      valid_q, valid_d;
  logic [COUNT_W-1:0]      count_q, count_d;
  logic [CAP_W-1:0]        cap_q;

  // Captured beat
  logic [KEY_W-1:0]        key_q;
  logic                    ok_q;
  logic [CONN_ID_BITS-1:0] conn_in_q;

  // Lookup results
  logic              hit_q, full_q;
  logic [SLOT_W-1:0] hit_slot_q, victim_slot_q, free_slot_q;

  // Result register
  lkc_status_e             out_status_q;
  logic [SLOT_W-1:0]       out_slot_q;
  logic [CONN_ID_BITS-1:0] out_conn_q;
  logic [KEY_W-1:0]        out_evict_q;
  logic [COUNT_W-1:0]      out_occ_q;

  // Lookup combinational signals
  logic [ENTRIES-1:0] match, victim_oh;
  logic [SLOT_W-1:0]  hit_slot, victim_slot, free_slot;
  logic [RANK_W-1:0]  oldest_rank;
  logic [COUNT_W-1:0] eff_cap;

  // Commit combinational signals
  logic              insert;
  logic [SLOT_W-1:0] tgt_slot;
  logic [RANK_W-1:0] hit_rank;
  lkc_status_e       status_d;

  // Capacity clamp to 1 .. ENTRIES
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = COUNT_W'(1);
    end else if (COUNT_W'(cap_q) > COUNT_W'(ENTRIES)) begin
      eff_cap = COUNT_W'(ENTRIES);
    end else begin
      eff_cap = COUNT_W'(cap_q);
    end
  end

  // Tag compare, oldest entry, lowest free slot
  assign oldest_rank = RANK_W'(count_q - COUNT_W'(1));
  always_comb begin
    hit_slot    = '0;
    victim_slot = '0;
    free_slot   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]     = valid_q[i] && (keys_q[i] == key_q);
      victim_oh[i] = valid_q[i] && (rank_q[i] == oldest_rank);
      if (match[i])     hit_slot    = hit_slot    | SLOT_W'(i);
      if (victim_oh[i]) victim_slot = victim_slot | SLOT_W'(i);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_slot = SLOT_W'(i);
    end
  end

  // Commit: recency update, insert, result
  assign insert   = !hit_q && ok_q;
  assign tgt_slot = hit_q ? hit_slot_q : (full_q ? victim_slot_q : free_slot_q);
  assign hit_rank = rank_q[hit_slot_q];

  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_d[i] = rank_q[i];
      if (hit_q) begin
        if (SLOT_W'(i) == hit_slot_q) begin
          rank_d[i] = '0;
        end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
          rank_d[i] = RANK_W'(rank_q[i] + 1'b1);
        end
      end else if (insert) begin
        if (SLOT_W'(i) == tgt_slot) begin
          rank_d[i] = '0;
        end else if (valid_q[i]) begin
          rank_d[i] = RANK_W'(rank_q[i] + 1'b1);
        end
      end
    end
    if (insert) begin
      valid_d[tgt_slot] = 1'b1;
      if (!full_q) count_d = COUNT_W'(count_q + 1'b1);
    end
    if (hit_q) begin
      status_d = STAT_HIT;
    end else if (!ok_q) begin
      status_d = STAT_FAIL;
    end else if (full_q) begin
      status_d = STAT_EVICT;
    end else begin
      status_d = STAT_INSERT;
    end
  end

  // Control-side registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      cap_q   <= CAP_W'(CAP_RESET);
      for (int i = 0; i < ENTRIES; i++) rank_q[i] <= '0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (cmd_i.commit) begin
        valid_q <= valid_d;
        count_q <= count_d;
        for (int i = 0; i < ENTRIES; i++) rank_q[i] <= rank_d[i];
      end
    end
  end

  // Payload registers: beat capture, lookup results, store, result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      key_q     <= key_i;
      ok_q      <= prepare_ok_i;
      conn_in_q <= new_conn_id_i;
    end
    if (cmd_i.lookup) begin
      hit_q         <= |match;
      hit_slot_q    <= hit_slot;
      victim_slot_q <= victim_slot;
      free_slot_q   <= free_slot;
      full_q        <= (count_q >= eff_cap);
    end
    if (cmd_i.commit) begin
      if (insert) begin
        keys_q[tgt_slot]  <= key_q;
        conns_q[tgt_slot] <= conn_in_q;
      end
      out_status_q <= status_d;
      out_slot_q   <= (hit_q || ok_q) ? tgt_slot : '0;
      out_conn_q   <= hit_q ? conns_q[hit_slot_q] : (ok_q ? conn_in_q : '0);
      out_evict_q  <= (insert && full_q) ? keys_q[victim_slot_q] : '0;
      out_occ_q    <= count_d;
    end
  end

  assign status_o        = out_status_q;
  assign slot_o          = out_slot_q;
  assign entry_conn_id_o = out_conn_q;
  assign evicted_key_o   = out_evict_q;
  assign occupancy_o     = out_occ_q;

  // Fill count tracks the valid bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) == $countones(valid_q))
    else $error("fill count out of step with valid bits");

  // Keys of valid entries are unique
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.lookup |-> $onehot0(match))
    else $error("duplicate key in store");

  // Fill count never passes the store size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_W'(ENTRIES))
    else $error("fill count above store size");

endmodule

// ===== tb/testbench.sv =====
// testbench: self-checking bench for lru_keyed_entry_cache, with an in-bench LRU predictor.
// Depends on lkc_pkg and the lru_keyed_entry_cache RTL only; reads no files.
`timescale 1ns / 1ps

module testbench;
  import lkc_pkg::*;

  // One result beat as the block reports it
  typedef struct {
    lkc_status_e               status;
    logic [SLOT_W-1:0]         slot;
    logic [CONN_ID_BITS-1:0]   conn;
    logic [KEY_W-1:0]          evk;
    logic [COUNT_W-1:0]        occ;
  } lookup_res_t;

  // Directed row: either a capacity write or a lookup, optionally with a fixed answer
  typedef struct {
    bit                        is_cfg;
    logic [CAP_W-1:0]          cap;
    logic [KEY_W-1:0]          key;
    logic                      ok;
    logic [CONN_ID_BITS-1:0]   conn;
    bit                        typed;
    lookup_res_t               res;
  } stim_row_t;

  localparam int N_PHASES   = 10;
  localparam int PHASE_LEN  = 150;
  localparam int SETTLE_CYC = 4;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CAP_W-1:0]        cfg_wdata;
  logic                    in_valid;
  logic                    in_stall;
  logic [KEY_W-1:0]        req_key;
  logic                    req_prepare_ok;
  logic [CONN_ID_BITS-1:0] req_conn;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [STATUS_W-1:0]     rsp_status;
  logic [SLOT_W-1:0]       rsp_slot;
  logic [CONN_ID_BITS-1:0] rsp_conn;
  logic [KEY_W-1:0]        rsp_evicted;
  logic [COUNT_W-1:0]      rsp_occupancy;

  // Predictor copy of the store
  logic [KEY_W-1:0]        cache_key [ENTRIES];
  logic [CONN_ID_BITS-1:0] cache_conn[ENTRIES];
  bit                      cache_live[ENTRIES];
  int                      cache_age [ENTRIES];
  int                      cache_fill;
  int                      cache_cap;

  lookup_res_t pending_results[$];
  bit          use_typed;
  lookup_res_t typed_res;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches    = 0;
  int n_hit = 0, n_insert = 0, n_evict = 0, n_fail = 0, n_cfg = 0;
  int results_seen  = 0;

  lru_keyed_entry_cache u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .key_i           (req_key),
    .prepare_ok_i    (req_prepare_ok),
    .new_conn_id_i   (req_conn),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .status_o        (rsp_status),
    .slot_o          (rsp_slot),
    .entry_conn_id_o (rsp_conn),
    .evicted_key_o   (rsp_evicted),
    .occupancy_o     (rsp_occupancy)
  );

  always #4 clk = ~clk;

  // Receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // LRU lookup: hit refreshes, miss inserts (evicting the oldest when full) or fails
  function automatic lookup_res_t predict_lookup(input logic [KEY_W-1:0] k, input logic ok,
                                                 input logic [CONN_ID_BITS-1:0] c);
    lookup_res_t r;
    int hit;
    int victim;
    int worst;
    int eff_cap;
    int age_limit;
    r.status = STAT_FAIL;
    r.slot   = '0;
    r.conn   = '0;
    r.evk    = '0;
    hit      = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (cache_live[i] && cache_key[i] == k) hit = i;
    if (hit >= 0) begin
      age_limit = cache_age[hit];
      for (int i = 0; i < ENTRIES; i++)
        if (cache_live[i] && cache_age[i] < age_limit) cache_age[i]++;
      cache_age[hit] = 0;
      r.status = STAT_HIT;
      r.slot   = SLOT_W'(hit);
      r.conn   = cache_conn[hit];
      n_hit++;
    end else if (!ok) begin
      n_fail++;
    end else begin
      // zero means one, anything past the store size means the whole store
      eff_cap = (cache_cap < 1) ? 1 : ((cache_cap > ENTRIES) ? ENTRIES : cache_cap);
      victim  = -1;
      worst   = 0;
      if (cache_fill >= eff_cap) begin
        for (int i = 0; i < ENTRIES; i++)
          if (cache_live[i] && (victim < 0 || cache_age[i] > worst)) begin
            victim = i;
            worst  = cache_age[i];
          end
        r.evk              = cache_key[victim];
        cache_live[victim] = 1'b0;
        cache_fill--;
        r.status = STAT_EVICT;
        n_evict++;
      end else begin
        for (int i = ENTRIES - 1; i >= 0; i--)
          if (!cache_live[i]) victim = i;
        r.status = STAT_INSERT;
        n_insert++;
      end
      for (int i = 0; i < ENTRIES; i++)
        if (cache_live[i]) cache_age[i]++;
      cache_key[victim]  = k;
      cache_conn[victim] = c;
      cache_live[victim] = 1'b1;
      cache_age[victim]  = 0;
      cache_fill++;
      r.slot = SLOT_W'(victim);
      r.conn = c;
    end
    r.occ = COUNT_W'(cache_fill);
    return r;
  endfunction

  // Edge monitor: check the result beat first, then predict the accepted lookup beat
  always @(posedge clk) begin
    lookup_res_t e;
    lookup_res_t p;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending (status %0d)", rsp_status));
      end else begin
        e = pending_results.pop_front();
        if (rsp_status !== e.status)
          report_mismatch($sformatf("status %0d, wanted %s", rsp_status, e.status.name()));
        if (rsp_slot !== e.slot)
          report_mismatch($sformatf("slot %0d, wanted %0d", rsp_slot, e.slot));
        if (rsp_conn !== e.conn)
          report_mismatch($sformatf("conn id %h, wanted %h", rsp_conn, e.conn));
        if (rsp_evicted !== e.evk)
          report_mismatch($sformatf("evicted key %h, wanted %h", rsp_evicted, e.evk));
        if (rsp_occupancy !== e.occ)
          report_mismatch($sformatf("occupancy %0d, wanted %0d", rsp_occupancy, e.occ));
      end
    end
    if (rst_n && in_valid === 1'b1 && in_stall === 1'b0) begin
      p = predict_lookup(req_key, req_prepare_ok, req_conn);
      pending_results.push_back(use_typed ? typed_res : p);
    end
  end

  // Present one lookup beat (after an optional gap) and hold it until taken
  task automatic send_lookup(input logic [KEY_W-1:0] k, input logic ok,
                             input logic [CONN_ID_BITS-1:0] c, input bit typed,
                             input lookup_res_t tres);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    req_key        <= k;
    req_prepare_ok <= ok;
    req_conn       <= c;
    use_typed      = typed;
    typed_res      = tres;
    in_valid       <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
  endtask

  // Hold off the sender until every outstanding result has drained
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cache_cap = int'(v);
    n_cfg++;
  endtask

  // Hard stop in case the handshake hangs
  initial begin
    #2_000_000;
    $display("ERROR: run timed out");
    $display("FAILURE");
    $finish;
  end

  initial begin
    stim_row_t        dir_rows[20];
    lookup_res_t      no_res;
    int               phase_caps[N_PHASES];
    logic [KEY_W-1:0] key_pool[$];
    logic [KEY_W-1:0] k;
    logic             ok;
    int               pool_len;
    int               pick;
    int               eff;

    in_valid       = 1'b0;
    req_key        = '0;
    req_prepare_ok = 1'b0;
    req_conn       = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    rst_n          = 1'b0;
    use_typed      = 1'b0;
    cache_fill     = 0;
    cache_cap      = CAP_RESET;
    for (int i = 0; i < ENTRIES; i++) begin
      cache_live[i] = 1'b0;
      cache_age[i]  = 0;
    end
    no_res = '{STAT_HIT, '0, '0, '0, '0};

    // Directed table: empty store, extremes of key and conn id, capacity clamps,
    // capacity dropped below occupancy, eviction order
    dir_rows = '{
      '{0, 5'd0,  64'd0,                  1'b0, 8'h33, 1, '{STAT_FAIL,   4'd0, 8'h00, 64'd0, 5'd0}},
      '{0, 5'd0,  64'd0,                  1'b1, 8'h00, 1, '{STAT_INSERT, 4'd0, 8'h00, 64'd0, 5'd1}},
      '{0, 5'd0,  64'd0,                  1'b0, 8'hFF, 1, '{STAT_HIT,    4'd0, 8'h00, 64'd0, 5'd1}},
      '{0, 5'd0,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'hFF, 1, '{STAT_INSERT, 4'd1, 8'hFF, 64'd0, 5'd2}},
      '{0, 5'd0,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'h00, 0, no_res},
      '{0, 5'd0,  64'h8000_0000_0000_0000, 1'b0, 8'hA5, 1, '{STAT_FAIL,   4'd0, 8'h00, 64'd0, 5'd2}},
      '{1, 5'd0,  64'd0,                  1'b0, 8'h00, 0, no_res},
      '{0, 5'd0,  64'd5,                  1'b1, 8'h5A, 0, no_res},
      '{0, 5'd0,  64'd6,                  1'b1, 8'h01, 0, no_res},
      '{0, 5'd0,  64'd5,                  1'b0, 8'hC3, 0, no_res},
      '{0, 5'd0,  64'd7,                  1'b0, 8'h3C, 1, '{STAT_FAIL,   4'd0, 8'h00, 64'd0, 5'd2}},
      '{1, 5'd31, 64'd0,                  1'b0, 8'h00, 0, no_res},
      '{0, 5'd0,  64'd1,                  1'b1, 8'h80, 0, no_res},
      '{0, 5'd0,  64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 8'h7F, 0, no_res},
      '{1, 5'd3,  64'd0,                  1'b0, 8'h00, 0, no_res},
      '{0, 5'd0,  64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 8'h55, 0, no_res},
      '{0, 5'd0,  64'h5555_5555_5555_5555, 1'b1, 8'hAA, 0, no_res},
      '{0, 5'd0,  64'd6,                  1'b0, 8'h0F, 0, no_res},
      '{1, 5'd16, 64'd0,                  1'b0, 8'h00, 0, no_res},
      '{0, 5'd0,  64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 8'hFE, 0, no_res}
    };
    phase_caps = '{16, 1, 31, 0, 4, 17, 8, 2, 16, 12};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg)
        write_capacity(dir_rows[i].cap);
      else
        send_lookup(dir_rows[i].key, dir_rows[i].ok, dir_rows[i].conn,
                    dir_rows[i].typed, dir_rows[i].res);
    end

    // Random part: mostly keys from a small working set so hits, inserts and
    // evictions all show up; some fresh keys and one-bit near misses as noise
    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_capacity(CAP_W'(phase_caps[ph]));
      eff      = (phase_caps[ph] < 1) ? 1 : ((phase_caps[ph] > ENTRIES) ? ENTRIES : phase_caps[ph]);
      pool_len = eff + $urandom_range(0, 6);
      key_pool.delete();
      for (int j = 0; j < pool_len; j++) begin
        case ($urandom_range(0, 7))
          0:       key_pool.push_back('0);
          1:       key_pool.push_back('1);
          default: key_pool.push_back({$urandom, $urandom});
        endcase
      end
      for (int n = 0; n < PHASE_LEN; n++) begin
        // receiver-idle, then sender-idle, then flat out
        if (ph < 3) begin
          send_idle_pct = 19;
          recv_idle_pct = 54;
        end else if (ph < 6) begin
          send_idle_pct = 54;
          recv_idle_pct = 19;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
          k  = key_pool[$urandom_range(0, pool_len - 1)];
          ok = ($urandom_range(0, 9) != 0);
        end else if (pick < 92) begin
          k  = {$urandom, $urandom};
          ok = 1'($urandom_range(0, 1));
        end else begin
          k  = key_pool[$urandom_range(0, pool_len - 1)] ^ (64'd1 << $urandom_range(0, 63));
          ok = 1'($urandom_range(0, 1));
        end
        send_lookup(k, ok, CONN_ID_BITS'($urandom), 1'b0, no_res);
        // occasional full drain mid-stream
        if (n == PHASE_LEN / 2 || $urandom_range(0, 199) == 0)
          drain_results();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);

    $display("Covered %0d results: %0d hits, %0d inserts, %0d evictions, %0d refused prepares,",
             results_seen, n_hit, n_insert, n_evict, n_fail);
    $display("over %0d capacity writes including 0, 1, 16 and 31; %0d mismatches.",
             n_cfg, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lkc_pkg.sv
rtl/lkc_ctrl.sv
rtl/lkc_dpath.sv
rtl/lru_keyed_entry_cache.sv
tb/testbench.sv
